// File: rtl/core/lrmw_pkg.sv
// Shared types, constants and helpers of the local atomic read-modify-write unit.
package lrmw_pkg;

  localparam int unsigned MemWords = 4096;
  localparam int unsigned WordIdxW = $clog2(MemWords);
  localparam int unsigned AddrW    = 32;
  localparam int unsigned WordNumW = AddrW - 3;

  typedef enum logic [3:0] {
    KIND_INC  = 4'd0,
    KIND_DEC  = 4'd1,
    KIND_LOAD = 4'd2,
    KIND_XCHG = 4'd3,
    KIND_ADD  = 4'd4,
    KIND_SUB  = 4'd5,
    KIND_SMIN = 4'd6,
    KIND_SMAX = 4'd7,
    KIND_UMIN = 4'd8,
    KIND_UMAX = 4'd9,
    KIND_AND  = 4'd10,
    KIND_OR   = 4'd11,
    KIND_XOR  = 4'd12
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADDR,
    ST_READ,
    ST_MODIFY
  } state_e;

  typedef struct packed {
    logic [3:0]         kind;
    logic               active;
    logic signed [31:0] base_address;
    logic signed [31:0] element_index;
    logic signed [15:0] index_scale;
    logic signed [31:0] byte_offset;
    logic [63:0]        operand;
    logic [63:0]        passthru_value;
  } in_t;

  typedef struct packed {
    logic [63:0] old_value;
    logic        range_error;
  } out_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;   // take the input beat
    logic mul;       // register index times scale
    logic addr;      // register word number and range flag
    logic rd;        // issue the memory read
    logic wr;        // write back the new word
    logic load_out;  // load the result register
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic active;
    logic range_err;
  } status_t;

  function automatic logic [63:0] apply_op(logic [3:0] kind, logic [63:0] old,
                                           logic [63:0] src);
    logic [63:0] res;
    res = old;
    unique case (kind)
      KIND_INC:  res = old + 64'd1;
      KIND_DEC:  res = old - 64'd1;
      KIND_XCHG: res = src;
      KIND_ADD:  res = old + src;
      KIND_SUB:  res = old - src;
      KIND_SMIN: res = ($signed(src) < $signed(old)) ? src : old;
      KIND_SMAX: res = ($signed(src) > $signed(old)) ? src : old;
      KIND_UMIN: res = (src < old) ? src : old;
      KIND_UMAX: res = (src > old) ? src : old;
      KIND_AND:  res = old & src;
      KIND_OR:   res = old | src;
      KIND_XOR:  res = old ^ src;
      default:   res = old;  // load and unused codes leave the word as is
    endcase
    return res;
  endfunction

endpackage

// File: rtl/core/local_atomic_rmw_int64.sv
// Top level of the local atomic read-modify-write unit on 64-bit shared words.
//
// Usage: one input beat (in_i) is one lane access, taken when in_valid_i is
// high and in_stall_o is low. The byte address base + index * scale + offset
// wraps to 32 bits; bits [2:0] are dropped and the rest selects the word.
// An active in-range beat reads the word, applies the operation in kind,
// writes the result back and returns the old word on out_o. Inactive beats
// return passthru_value; active out-of-range beats return passthru_value
// with range_error set and leave memory alone.
// The result register is loaded from the MODIFY state for a memory access,
// or from the READ state for an inactive or out-of-range beat. Beats are
// handled one at a time: a new beat is taken only once the controller is
// back in idle. Multiply, address add, RAM read and write back each take a
// controller state.
// Output stall: the result register holds while out_stall_i is high; the
// unit finishes the next beat up to write back and waits there.
// Reset clears the controller and output valid; memory contents are not
// cleared and a word must be written before it is read.
module local_atomic_rmw_int64 (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lrmw_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lrmw_pkg::out_t out_o
);

  lrmw_pkg::cmd_t    cmd;
  lrmw_pkg::status_t status;

  // Sequence each beat through its states.
  lrmw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Hold the beat, compute the address, and run the read-modify-write.
  lrmw_dp u_dp (
    .clk_i    (clk_i),
    .in_i     (in_i),
    .cmd_i    (cmd),
    .status_o (status),
    .out_o    (out_o)
  );

`ifndef ASSERT_OFF
  // One beat at a time: an accepted beat blocks the input next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a beat is in flight");

  // Write back only for active, in-range beats.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr |-> status.active && !status.range_err)
    else $error("memory write for inactive or out-of-range beat");

  // Never overwrite a result still waiting on a stalled receiver.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || !out_stall_i))
    else $error("result register overwritten while stalled");

  // A write always comes with its result load.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr |-> cmd.load_out)
    else $error("write back without result");
`endif

endmodule

// File: rtl/core/lrmw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lrmw_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/lrmw_ctrl.sv
// Controller FSM: sequences one beat through multiply, address, read and write back.
module lrmw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  lrmw_pkg::status_t status_i,
  output lrmw_pkg::cmd_t    cmd_o
);

  lrmw_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lrmw_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = lrmw_pkg::ST_MUL;
      end
      lrmw_pkg::ST_MUL:  state_d = lrmw_pkg::ST_ADDR;
      lrmw_pkg::ST_ADDR: state_d = lrmw_pkg::ST_READ;
      lrmw_pkg::ST_READ: begin
        if (status_i.active && !status_i.range_err) begin
          state_d = lrmw_pkg::ST_MODIFY;
        end else if (out_free) begin
          state_d = lrmw_pkg::ST_IDLE;
        end
      end
      lrmw_pkg::ST_MODIFY: begin
        if (out_free) state_d = lrmw_pkg::ST_IDLE;
      end
      default: state_d = lrmw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      lrmw_pkg::ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      lrmw_pkg::ST_MUL:  cmd_o.mul  = 1'b1;
      lrmw_pkg::ST_ADDR: cmd_o.addr = 1'b1;
      lrmw_pkg::ST_READ: begin
        if (status_i.active && !status_i.range_err) begin
          cmd_o.rd = 1'b1;
        end else begin
          cmd_o.load_out = out_free;
        end
      end
      lrmw_pkg::ST_MODIFY: begin
        cmd_o.wr       = out_free;
        cmd_o.load_out = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lrmw_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/core/lrmw_dp.sv
// Datapath: address arithmetic, range check, shared word memory, operation and result register.
module lrmw_dp (
  input  logic              clk_i,
  input  lrmw_pkg::in_t     in_i,
  input  lrmw_pkg::cmd_t    cmd_i,
  output lrmw_pkg::status_t status_o,
  output lrmw_pkg::out_t    out_o
);

  lrmw_pkg::in_t  item_q;
  lrmw_pkg::out_t out_q, out_d;
  logic [31:0]    prod_q;
  logic [31:0]    prod_full;
  logic [31:0]    scale_ext;
  logic [31:0]    addr_sum;
  logic [lrmw_pkg::WordNumW-1:0] word_num;
  logic [lrmw_pkg::WordIdxW-1:0] word_idx_q;
  logic           err_q;
  logic [63:0]    rdata;
  logic [63:0]    new_word;

  assign scale_ext = {{16{item_q.index_scale[15]}}, item_q.index_scale};
  // Only the low 32 bits of index times scale reach the address.
  assign prod_full = $unsigned(item_q.element_index) * scale_ext;
  assign addr_sum  = item_q.base_address + prod_q + item_q.byte_offset;
  assign word_num  = addr_sum[31:3];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_i;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_full;
    end
    if (cmd_i.addr) begin
      word_idx_q <= word_num[lrmw_pkg::WordIdxW-1:0];
      err_q      <= word_num >= lrmw_pkg::WordNumW'(lrmw_pkg::MemWords);
    end
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  lrmw_ram #(
    .Width (64),
    .Depth (lrmw_pkg::MemWords)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr),
    .waddr_i (word_idx_q),
    .wdata_i (new_word),
    .re_i    (cmd_i.rd),
    .raddr_i (word_idx_q),
    .rdata_o (rdata)
  );

  assign new_word = lrmw_pkg::apply_op(item_q.kind, rdata, item_q.operand);

  always_comb begin
    out_d.old_value   = item_q.passthru_value;
    out_d.range_error = 1'b0;
    if (item_q.active) begin
      if (err_q) begin
        out_d.range_error = 1'b1;
      end else begin
        out_d.old_value = rdata;
      end
    end
  end

  assign status_o.active    = item_q.active;
  assign status_o.range_err = err_q;
  assign out_o              = out_q;

endmodule

// File: verif/lrmw_checker.sv
// Scoreboard that predicts and checks every result beat of local_atomic_rmw_int64.
module lrmw_checker
  import lrmw_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  in_t  in_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  out_t out_i,
  output int   errors_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // One expected result; the old word is unknown on the exchange that seeds a word.
  typedef struct {
    out_t beat;
    bit   old_known;
  } rmw_due_t;

  rmw_due_t    due_q[$];
  logic [63:0] shadow_words [MemWords];
  bit          shadow_set   [MemWords];
  int          err_count;

  initial begin
    err_count = 0;
  end

  function automatic logic [63:0] modify_word(logic [3:0] kind, logic [63:0] old,
                                              logic [63:0] src);
    case (kind)
      KIND_INC:  return old + 64'd1;
      KIND_DEC:  return old - 64'd1;
      KIND_XCHG: return src;
      KIND_ADD:  return old + src;
      KIND_SUB:  return old - src;
      KIND_SMIN: return ($signed(src) < $signed(old)) ? src : old;
      KIND_SMAX: return ($signed(src) > $signed(old)) ? src : old;
      KIND_UMIN: return (src < old) ? src : old;
      KIND_UMAX: return (src > old) ? src : old;
      KIND_AND:  return old & src;
      KIND_OR:   return old | src;
      KIND_XOR:  return old ^ src;
      default:   return old;
    endcase
  endfunction

  task automatic flag(string what, logic [63:0] want, logic [63:0] got);
    err_count++;
    if (err_count <= 10) begin
      $display("%0t ns: mismatch on %s: expected %h, got %h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : watch
    rmw_due_t          want;
    rmw_due_t          fresh;
    logic [31:0]       scale32;
    logic [31:0]       addr;
    logic [WordNumW-1:0] wnum;
    logic [WordIdxW-1:0] w;
    if (rst_ni) begin
      // Retire the result beat first; a beat taken at this edge cannot answer yet.
      if (out_valid_i && !out_stall_i) begin
        if (due_q.size() == 0) begin
          flag("result beat with nothing outstanding", '0, out_i.old_value);
        end else begin
          want = due_q.pop_front();
          if (want.old_known && out_i.old_value !== want.beat.old_value) begin
            flag("old_value", want.beat.old_value, out_i.old_value);
          end
          if (out_i.range_error !== want.beat.range_error) begin
            flag("range_error", 64'(want.beat.range_error), 64'(out_i.range_error));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        scale32 = {{16{in_i.index_scale[15]}}, in_i.index_scale};
        addr = 32'(in_i.base_address) + 32'(in_i.element_index) * scale32
             + 32'(in_i.byte_offset);
        wnum = addr[31:3];
        fresh.beat.old_value   = in_i.passthru_value;
        fresh.beat.range_error = 1'b0;
        fresh.old_known        = 1'b1;
        if (in_i.active) begin
          if (wnum >= MemWords) begin
            fresh.beat.range_error = 1'b1;
          end else begin
            w = wnum[WordIdxW-1:0];
            fresh.old_known      = shadow_set[w];
            fresh.beat.old_value = shadow_words[w];
            shadow_words[w]      = modify_word(in_i.kind, shadow_words[w], in_i.operand);
            if (in_i.kind == KIND_XCHG) shadow_set[w] = 1'b1;
          end
        end
        due_q.push_back(fresh);
      end
      errors_o  <= err_count;
      pending_o <= due_q.size();
    end
  end

endmodule

// File: verif/tb_local_atomic_rmw_int64.sv
// Testbench top for local_atomic_rmw_int64: stimulus, flow control and verdict.
module tb_local_atomic_rmw_int64;
  import lrmw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Kind codes past the last defined operation; the unit treats them as a load.
  localparam logic [3:0] KindSpareLo = 4'd13;
  localparam logic [3:0] KindSpareHi = 4'd15;

  localparam int RandomBeats = 530;
  localparam int CalmBeats   = 100;   // tail of the run with no idling at all
  localparam int HoldAfter   = 150;   // results drained before the long hold-off
  localparam int HoldCycles  = 80;
  localparam int DrainCycles = 20;    // extra cycles after the last result is out
  localparam int CycleLimit  = 100000;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_beat   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_beat;

  int fault_count;
  int pending_count;
  int cycles = 0;
  bit calm   = 1'b0;

  // Words that hold a defined value. The first access to any word must be an
  // exchange, since every operation reads the word before writing it back.
  bit                  seeded [MemWords];
  logic [WordIdxW-1:0] pool [16];

  local_atomic_rmw_int64 DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_i       (in_beat),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_o      (out_beat)
  );

  lrmw_checker rmw_check (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_i       (in_beat),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_i      (out_beat),
    .errors_o   (fault_count),
    .pending_o  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the unit hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Random 64-bit value, biased now and then toward the edges that matter for
  // wrapping arithmetic and for signed against unsigned compares.
  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 64'h0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7FFF_FFFF_FFFF_FFFF;
      4: return 64'd1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Random address fields; base is fixed up later so the sum lands where wanted.
  function automatic in_t random_fields(logic [3:0] kind, logic active);
    in_t b;
    b.kind           = kind;
    b.active         = active;
    b.element_index  = $urandom;
    b.index_scale    = 16'($urandom);
    b.byte_offset    = $urandom;
    b.base_address   = $urandom;
    b.operand        = rand_word();
    b.passthru_value = {$urandom, $urandom};
    // Keep some plain array-style addressing in the mix too.
    if ($urandom_range(0, 3) == 0) begin
      b.index_scale   = ($urandom_range(0, 1) != 0) ? 16'sd8 : 16'sd0;
      b.element_index = $urandom_range(0, 255);
    end
    return b;
  endfunction

  // Solve for base so that base + index * scale + offset wraps to addr.
  function automatic in_t steer(in_t b, logic [31:0] addr);
    logic [31:0] scale32;
    logic [31:0] prod;
    scale32 = {{16{b.index_scale[15]}}, b.index_scale};
    prod    = 32'(b.element_index) * scale32;
    b.base_address = addr - prod - 32'(b.byte_offset);
    return b;
  endfunction

  function automatic logic [31:0] word_addr(logic [WordIdxW-1:0] w);
    return (32'(w) << 3) | 32'($urandom_range(0, 7));
  endfunction

  function automatic in_t at_word(logic [3:0] kind, logic [WordIdxW-1:0] w,
                                  logic [63:0] src);
    in_t b;
    b         = random_fields(kind, 1'b1);
    b.operand = src;
    return steer(b, word_addr(w));
  endfunction

  // Offer one beat and hold it until taken. Returns at the accepting edge, so
  // the next beat goes out back to back unless a gap is drawn.
  task automatic send_beat(in_t b);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_beat  <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Mostly well-formed accesses to a small set of hot words, so that the same
  // word is hit back to back; the rest are random words, inactive lanes and range errors.
  task automatic pick_beat(output in_t b, inout logic [WordIdxW-1:0] last_word);
    int                  r;
    logic [3:0]          kind;
    logic [WordIdxW-1:0] w;
    r    = $urandom_range(0, 99);
    kind = 4'($urandom_range(0, int'(KIND_XOR)));
    if ($urandom_range(0, 39) == 0) begin
      kind = 4'($urandom_range(int'(KindSpareLo), int'(KindSpareHi)));
    end
    if (r < 8) begin
      b = steer(random_fields(kind, 1'b0), $urandom);
    end else if (r < 16) begin
      b = steer(random_fields(kind, 1'b1), $urandom_range(32'hFFFF_FFFF, MemWords * 8));
    end else begin
      if (r < 40) begin
        w = last_word;
      end else if (r < 90) begin
        w = pool[$urandom_range(0, 15)];
      end else begin
        w = WordIdxW'($urandom_range(0, MemWords - 1));
      end
      if (!seeded[w]) kind = KIND_XCHG;
      seeded[w] = 1'b1;
      b = steer(random_fields(kind, 1'b1), word_addr(w));
      last_word = w;
    end
  endtask

  // Output side: short random stall bursts, one long hold-off once the run is
  // well under way so the unit backs up into its input, and none in the tail.
  initial begin : drain
    int burst;
    int taken;
    bit held;
    burst = 0;
    taken = 0;
    held  = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) taken++;
      if (!held && taken >= HoldAfter) begin
        held  = 1'b1;
        burst = HoldCycles;
      end else if (burst == 0 && !calm && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 5);
      end
      out_stall <= (burst != 0);
      if (burst != 0) burst--;
    end
  end

  initial begin : stimulus
    in_t                 b;
    logic [WordIdxW-1:0] last_word;
    logic [WordIdxW-1:0] top_word;
    top_word  = WordIdxW'(MemWords - 1);
    last_word = '0;
    pool[0]   = '0;
    pool[1]   = top_word;
    pool[2]   = WordIdxW'(1);
    for (int i = 3; i < 16; i++) pool[i] = WordIdxW'($urandom_range(0, MemWords - 1));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Seed word 0 through an all-zero address; the old word is not defined yet.
    b         = '0;
    b.kind    = KIND_XCHG;
    b.active  = 1'b1;
    b.operand = '1;
    send_beat(b);
    seeded[0] = 1'b1;

    // Walk every operation over word 0; values are chosen to hit the wraps and
    // the signed/unsigned split.
    send_beat(at_word(KIND_INC,  '0, rand_word()));            // all ones wraps to 0
    send_beat(at_word(KIND_DEC,  '0, rand_word()));            // 0 wraps to all ones
    send_beat(at_word(KIND_LOAD, '0, rand_word()));
    send_beat(at_word(KIND_ADD,  '0, 64'd1));                  // wraps to 0
    send_beat(at_word(KIND_SUB,  '0, 64'd1));                  // wraps to all ones
    send_beat(at_word(KIND_SMIN, '0, 64'h8000_0000_0000_0000));
    send_beat(at_word(KIND_SMAX, '0, 64'h7FFF_FFFF_FFFF_FFFF));
    send_beat(at_word(KIND_UMIN, '0, 64'h0));
    send_beat(at_word(KIND_UMAX, '0, '1));
    send_beat(at_word(KIND_AND,  '0, 64'h5555_5555_5555_5555));
    send_beat(at_word(KIND_OR,   '0, 64'hAAAA_AAAA_AAAA_AAAA));
    send_beat(at_word(KIND_XOR,  '0, {$urandom, $urandom}));
    send_beat(at_word(KindSpareLo, '0, {$urandom, $urandom}));
    send_beat(at_word(KindSpareHi, '0, {$urandom, $urandom}));

    // Last word of memory, reached through extreme index, scale and offset.
    b               = random_fields(KIND_XCHG, 1'b1);
    b.element_index = 32'sh7FFF_FFFF;
    b.index_scale   = 16'sh7FFF;
    b.byte_offset   = 32'sh8000_0000;
    send_beat(steer(b, (32'(top_word) << 3) | 32'd7));
    seeded[top_word] = 1'b1;
    b               = random_fields(KIND_INC, 1'b1);
    b.element_index = 32'sh8000_0000;
    b.index_scale   = 16'sh8000;
    b.byte_offset   = 32'sh7FFF_FFFF;
    send_beat(steer(b, 32'(top_word) << 3));

    // Range errors: first word past the end, a negative address, the very top.
    send_beat(steer(random_fields(KIND_ADD, 1'b1), MemWords * 8));
    send_beat(steer(random_fields(KIND_XCHG, 1'b1), 32'hFFFF_FFF8));
    send_beat(steer(random_fields(KIND_INC, 1'b1), 32'hFFFF_FFFF));

    // Inactive lanes: every field at ones, then a lane aimed at a live word.
    b        = '1;
    b.active = 1'b0;
    send_beat(b);
    b        = at_word(KIND_XCHG, '0, rand_word());
    b.active = 1'b0;
    send_beat(b);

    for (int n = 0; n < RandomBeats; n++) begin
      calm <= (n >= RandomBeats - CalmBeats);
      pick_beat(b, last_word);
      send_beat(b);
    end
    in_valid <= 1'b0;

    // One more edge so the count includes the last beat, then let it drain.
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (fault_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: local_atomic_rmw_int64.f
rtl/core/lrmw_pkg.sv
rtl/core/lrmw_ram.sv
rtl/core/lrmw_ctrl.sv
rtl/core/lrmw_dp.sv
rtl/core/local_atomic_rmw_int64.sv
verif/lrmw_checker.sv
verif/tb_local_atomic_rmw_int64.sv
